>>> src/rfidtat_pkg.sv
// rfidtat_pkg: types, codes and constants of the card access table
// transaction structs, opcode / result / register codes, uid normalization
// no dependencies
package rfidtat_pkg;

   // field widths fixed by the interface
   localparam int UID_LOW_W  = 64;
   localparam int UID_HIGH_W = 16;
   localparam int UID_LEN_W  = 4;
   localparam int ENTRIES_W  = 5;
   localparam int MS_W       = 16;
   localparam int CSR_IDX_W  = 3;

   localparam logic [MS_W-1:0]      MS_SAT      = '1;
   localparam logic [UID_LEN_W-1:0] UID_MAX_LEN = 4'd10;
   localparam logic [UID_LEN_W-1:0] UID_LEN_9   = 4'd9;

   // register reset values
   localparam logic [MS_W-1:0] DEBOUNCE_RESET   = 16'd1500;
   localparam logic [MS_W-1:0] BEEP_OK_RESET    = 16'd200;
   localparam logic [MS_W-1:0] BEEP_FAIL_RESET  = 16'd1000;
   localparam logic [MS_W-1:0] BEEP_LEARN_RESET = 16'd600;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_CARD_READ   = 3'd1,
      OP_ADD_TAG     = 3'd2,
      OP_TOGGLE_TAG  = 3'd3,
      OP_DELETE_TAG  = 3'd4,
      OP_CLEAR_ALL   = 3'd5,
      OP_START_LEARN = 3'd6
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_NONE       = 3'd0,
      KIND_APPLIED    = 3'd1,
      KIND_NO_MATCH   = 3'd2,
      KIND_TABLE_FULL = 3'd3,
      KIND_LEARNED    = 3'd4,
      KIND_CHECKED    = 3'd5,
      KIND_DEBOUNCED  = 3'd6,
      KIND_CHECK_OFF  = 3'd7
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CHECK_ENABLE  = 3'd0,
      REG_BUZZER_ENABLE = 3'd1,
      REG_DEBOUNCE_MS   = 3'd2,
      REG_BEEP_OK_MS    = 3'd3,
      REG_BEEP_FAIL_MS  = 3'd4,
      REG_BEEP_LEARN_MS = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [UID_LOW_W-1:0]  uid_low;
      logic [UID_HIGH_W-1:0] uid_high;
      logic [UID_LEN_W-1:0]  uid_len;
   } req_type;

   typedef struct packed {
      logic [2:0]            result_kind;
      logic                  authorized;
      logic [UID_LOW_W-1:0]  out_uid_low;
      logic [UID_HIGH_W-1:0] out_uid_high;
      logic [UID_LEN_W-1:0]  out_uid_len;
      logic                  buzzer_level;
      logic                  learning_flag;
      logic [ENTRIES_W-1:0]  entries_used;
   } rsp_type;

   typedef struct packed {
      logic [UID_LEN_W-1:0]  len;
      logic [UID_HIGH_W-1:0] high;
      logic [UID_LOW_W-1:0]  low;
   } uid_type;

   // one table word: active mark and normalized uid
   typedef struct packed {
      logic    active;
      uid_type uid;
   } entry_type;

   typedef struct packed {
      logic            check_enable;
      logic            buzzer_enable;
      logic [MS_W-1:0] debounce_ms;
      logic [MS_W-1:0] beep_ok_ms;
      logic [MS_W-1:0] beep_fail_ms;
      logic [MS_W-1:0] beep_learn_ms;
   } cfg_type;

   typedef struct packed {
      logic done;
      logic hit;
      logic hit_active;
      logic free_found;
   } scan_status_type;

   // clamp length to ten bytes and zero the bytes past it
   function automatic uid_type norm_uid(input logic [UID_LOW_W-1:0] lo,
                                        input logic [UID_HIGH_W-1:0] hi,
                                        input logic [UID_LEN_W-1:0] len);
      uid_type               u;
      logic [UID_LEN_W-1:0]  n;
      n = (len > UID_MAX_LEN) ? UID_MAX_LEN : len;
      u.len  = n;
      u.low  = '0;
      u.high = '0;
      for (int b = 0; b < 8; b++) begin
         if (UID_LEN_W'(b) < n) begin
            u.low[8*b +: 8] = lo[8*b +: 8];
         end
      end
      if (n >= UID_LEN_9) begin
         u.high[7:0] = hi[7:0];
      end
      if (n == UID_MAX_LEN) begin
         u.high[15:8] = hi[15:8];
      end
      return u;
   endfunction

endpackage

>>> src/rfidtat_ram.sv
// rfidtat_ram: generic single write port, single read port ram
// registered read data; no dependencies
module rfidtat_ram #(
   parameter int WIDTH = 85,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rfidtat_csr.sv
// rfidtat_csr: configuration registers of the card access table
// depends on rfidtat_pkg for register codes and reset values
module rfidtat_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfidtat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfidtat_pkg::MS_W-1:0]         csr_wdata,
   output rfidtat_pkg::cfg_type                 cfg
);
   import rfidtat_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always accepted: ready is tied high
   assign csr_ready = 1'b1;

   // register decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CHECK_ENABLE:  cfg_in.check_enable  = csr_wdata[0];
            REG_BUZZER_ENABLE: cfg_in.buzzer_enable = csr_wdata[0];
            REG_DEBOUNCE_MS:   cfg_in.debounce_ms   = csr_wdata;
            REG_BEEP_OK_MS:    cfg_in.beep_ok_ms    = csr_wdata;
            REG_BEEP_FAIL_MS:  cfg_in.beep_fail_ms  = csr_wdata;
            REG_BEEP_LEARN_MS: cfg_in.beep_learn_ms = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_enable  <= 1'b0;
         cfg_ff.buzzer_enable <= 1'b0;
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.beep_ok_ms    <= BEEP_OK_RESET;
         cfg_ff.beep_fail_ms  <= BEEP_FAIL_RESET;
         cfg_ff.beep_learn_ms <= BEEP_LEARN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/rfidtat_scan.sv
// rfidtat_scan: walks the table ram one entry a cycle looking for a uid
// reports first match and lowest free slot; depends on rfidtat_pkg
module rfidtat_scan #(
   parameter int TAGS = 16,
   localparam int AW = (TAGS > 1) ? $clog2(TAGS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  rfidtat_pkg::uid_type          key,
   input  logic [TAGS-1:0]               valid,
   input  rfidtat_pkg::entry_type        rd_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   output rfidtat_pkg::scan_status_type  status,
   output logic [AW-1:0]                 hit_idx,
   output logic [AW-1:0]                 free_idx
);
   import rfidtat_pkg::*;

   localparam int CW = $clog2(TAGS + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          issuing_ff, issuing_in;
   logic          cmp_ff, cmp_in;
   logic [AW-1:0] cmp_addr_ff, cmp_addr_in;
   logic          done_ff, done_in;
   logic          hit_ff, hit_in;
   logic          hit_active_ff, hit_active_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          match;
   logic          last;

   // issue one read a cycle, compare the word that comes back on the next cycle
   always_comb begin
      match = cmp_ff && valid[cmp_addr_ff] && (rd_data.uid == key);
      last  = cmp_ff && (cmp_addr_ff == AW'(TAGS - 1));

      cnt_in        = cnt_ff;
      issuing_in    = issuing_ff;
      cmp_in        = 1'b0;
      cmp_addr_in   = cmp_addr_ff;
      done_in       = done_ff;
      hit_in        = hit_ff;
      hit_active_in = hit_active_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;

      rd_en   = issuing_ff && !match;
      rd_addr = cnt_ff[AW-1:0];

      if (start) begin
         cnt_in        = '0;
         issuing_in    = 1'b1;
         done_in       = 1'b0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else begin
         // address side
         if (issuing_ff) begin
            cnt_in      = cnt_ff + CW'(1);
            cmp_in      = 1'b1;
            cmp_addr_in = cnt_ff[AW-1:0];
            if (cnt_ff == CW'(TAGS - 1)) begin
               issuing_in = 1'b0;
            end
         end
         // compare side
         if (cmp_ff && !valid[cmp_addr_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_addr_ff;
         end
         if (match) begin
            hit_in        = 1'b1;
            hit_idx_in    = cmp_addr_ff;
            hit_active_in = rd_data.active;
            issuing_in    = 1'b0;
            cmp_in        = 1'b0;
            done_in       = 1'b1;
         end else if (last) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         issuing_ff    <= 1'b0;
         cmp_ff        <= 1'b0;
         done_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         issuing_ff    <= issuing_in;
         cmp_ff        <= cmp_in;
         done_ff       <= done_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
      end
   end

   // payload side, no reset
   always_ff @(posedge clock) begin
      cmp_addr_ff   <= cmp_addr_in;
      hit_active_ff <= hit_active_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
   end

   assign status.done       = done_ff;
   assign status.hit        = hit_ff;
   assign status.hit_active = hit_active_ff;
   assign status.free_found = free_found_ff;
   assign hit_idx           = hit_idx_ff;
   assign free_idx          = free_idx_ff;

endmodule

>>> src/rfid_tag_access_table_core.sv
// card access table: uid table in ram, entry walk, buzzer and debounce timers
// card reads and add / toggle / delete walk the table ram one entry a cycle,
//   stopping early on a match; tick, clear all and learn skip the walk
// throughput: one transaction at a time; the next is accepted from the cycle in
//   which the result is posted, and a stalled earlier result holds back the commit
// reset: synchronous; clears valid marks, counters, timers and registers, no ram sweep
module rfid_tag_access_table_core #(
   parameter int TAGS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rfidtat_pkg::req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rfidtat_pkg::rsp_type                rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rfidtat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rfidtat_pkg::MS_W-1:0]        csr_wdata
);
   import rfidtat_pkg::*;

   localparam int AW = (TAGS > 1) ? $clog2(TAGS) : 1;
   localparam int TW = $clog2(TAGS + 1);

   cfg_type         cfg;
   state_type       state_ff, state_in;
   logic [2:0]      op_ff;
   uid_type         uid_ff;
   logic [TAGS-1:0] valid_ff, valid_in;
   logic [TW-1:0]   total_ff, total_in;
   logic [MS_W-1:0] ms_ff, ms_in;
   logic            learn_ff, learn_in;
   logic            beeping_ff, beeping_in;
   logic [MS_W-1:0] beep_elapsed_ff, beep_elapsed_in;
   logic [MS_W-1:0] beep_length_ff, beep_length_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            commit;
   logic            needs_scan;
   logic            scan_start;
   logic [MS_W-1:0] ms_inc;
   logic [MS_W-1:0] beep_inc;
   kind_type        kind;
   logic            auth;
   logic            show_uid;

   entry_type       ram_rd_data;
   logic            ram_rd_en;
   logic [AW-1:0]   ram_rd_addr;
   logic            ram_wr_en;
   logic [AW-1:0]   ram_wr_addr;
   entry_type       ram_wr_data;

   scan_status_type scan_status;
   logic [AW-1:0]   scan_hit_idx;
   logic [AW-1:0]   scan_free_idx;

   // configuration registers
   rfidtat_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // uid and active mark store
   rfidtat_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TAGS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // table walk
   rfidtat_scan #(
      .TAGS (TAGS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (scan_start),
      .key      (uid_ff),
      .valid    (valid_ff),
      .rd_data  (ram_rd_data),
      .rd_en    (ram_rd_en),
      .rd_addr  (ram_rd_addr),
      .status   (scan_status),
      .hit_idx  (scan_hit_idx),
      .free_idx (scan_free_idx)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // ops that look up the table
   assign needs_scan = (req_data.opcode == OP_CARD_READ) ||
                       (req_data.opcode == OP_ADD_TAG) ||
                       (req_data.opcode == OP_TOGGLE_TAG) ||
                       (req_data.opcode == OP_DELETE_TAG);

   // saturating millisecond counters
   assign ms_inc   = (ms_ff == MS_SAT) ? ms_ff : ms_ff + MS_W'(1);
   assign beep_inc = (beep_elapsed_ff == MS_SAT) ? beep_elapsed_ff
                                                 : beep_elapsed_ff + MS_W'(1);

   // sequencer and state update
   always_comb begin
      state_in        = state_ff;
      scan_start      = 1'b0;
      valid_in        = valid_ff;
      total_in        = total_ff;
      ms_in           = ms_ff;
      learn_in        = learn_ff;
      beeping_in      = beeping_ff;
      beep_elapsed_in = beep_elapsed_ff;
      beep_length_in  = beep_length_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = scan_free_idx;
      ram_wr_data     = '{active: 1'b1, uid: uid_ff};
      kind            = KIND_NONE;
      auth            = 1'b0;
      show_uid        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               scan_start = needs_scan;
               state_in   = needs_scan ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
               case (op_ff)
                  OP_TICK: begin
                     ms_in           = ms_inc;
                     beep_elapsed_in = beep_inc;
                     if (beeping_ff && (beep_inc > beep_length_ff || beep_inc == MS_SAT)) begin
                        beeping_in = 1'b0;
                     end
                  end
                  OP_CARD_READ: begin
                     if (!learn_ff && ms_ff < cfg.debounce_ms) begin
                        kind = KIND_DEBOUNCED;
                     end else begin
                        ms_in = '0;
                        if (learn_ff) begin
                           learn_in = 1'b0;
                           kind     = KIND_LEARNED;
                           show_uid = 1'b1;
                           if (cfg.buzzer_enable) begin
                              beeping_in      = 1'b1;
                              beep_elapsed_in = '0;
                              beep_length_in  = cfg.beep_learn_ms;
                           end
                        end else if (!cfg.check_enable) begin
                           kind = KIND_CHECK_OFF;
                        end else begin
                           auth     = scan_status.hit && scan_status.hit_active;
                           kind     = KIND_CHECKED;
                           show_uid = 1'b1;
                           if (cfg.buzzer_enable) begin
                              beeping_in      = 1'b1;
                              beep_elapsed_in = '0;
                              beep_length_in  = auth ? cfg.beep_ok_ms : cfg.beep_fail_ms;
                           end
                        end
                     end
                  end
                  OP_ADD_TAG: begin
                     if (scan_status.hit) begin
                        kind = KIND_APPLIED;
                     end else if (scan_status.free_found) begin
                        ram_wr_en               = 1'b1;
                        ram_wr_addr             = scan_free_idx;
                        valid_in[scan_free_idx] = 1'b1;
                        total_in                = total_ff + TW'(1);
                        kind                    = KIND_APPLIED;
                     end else begin
                        kind = KIND_TABLE_FULL;
                     end
                  end
                  OP_TOGGLE_TAG: begin
                     if (scan_status.hit) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = scan_hit_idx;
                        ram_wr_data = '{active: !scan_status.hit_active, uid: uid_ff};
                        kind        = KIND_APPLIED;
                     end else begin
                        kind = KIND_NO_MATCH;
                     end
                  end
                  OP_DELETE_TAG: begin
                     if (scan_status.hit) begin
                        valid_in[scan_hit_idx] = 1'b0;
                        if (total_ff != '0) begin
                           total_in = total_ff - TW'(1);
                        end
                        kind = KIND_APPLIED;
                     end else begin
                        kind = KIND_NO_MATCH;
                     end
                  end
                  OP_CLEAR_ALL: begin
                     valid_in = '0;
                     total_in = '0;
                     kind     = KIND_APPLIED;
                  end
                  OP_START_LEARN: begin
                     learn_in = 1'b1;
                     kind     = KIND_APPLIED;
                  end
                  default: begin
                     kind = KIND_NONE;
                  end
               endcase

               // result register
               rsp_valid_in              = 1'b1;
               rsp_data_in.result_kind   = kind;
               rsp_data_in.authorized    = auth;
               rsp_data_in.out_uid_low   = show_uid ? uid_ff.low : '0;
               rsp_data_in.out_uid_high  = show_uid ? uid_ff.high : '0;
               rsp_data_in.out_uid_len   = show_uid ? uid_ff.len : '0;
               rsp_data_in.buzzer_level  = beeping_in;
               rsp_data_in.learning_flag = learn_in;
               rsp_data_in.entries_used  = ENTRIES_W'(total_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         valid_ff        <= '0;
         total_ff        <= '0;
         ms_ff           <= '0;
         learn_ff        <= 1'b0;
         beeping_ff      <= 1'b0;
         beep_elapsed_ff <= '0;
         beep_length_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         valid_ff        <= valid_in;
         total_ff        <= total_in;
         ms_ff           <= ms_in;
         learn_ff        <= learn_in;
         beeping_ff      <= beeping_in;
         beep_elapsed_ff <= beep_elapsed_in;
         beep_length_ff  <= beep_length_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // captured transaction and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_data.opcode;
         uid_ff <= norm_uid(req_data.uid_low, req_data.uid_high, req_data.uid_len);
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // tag count tracks the valid marks
   a_total_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(total_ff))
      else $error("tag count differs from number of valid entries");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TW'(TAGS))
      else $error("tag count above table depth");

   a_commit_result: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished transaction did not post a result");

   a_learn_ends: assert property (@(posedge clock) disable iff (reset)
      (commit && op_ff == OP_CARD_READ && learn_ff) |=> !learn_ff)
      else $error("learn mode did not end on a card read");

endmodule

>>> dv/access_table_tb_pkg.sv
`timescale 1ns / 1ps
// access_table_tb_pkg: uid helper and scoreboard class for the card access table bench
// depends on rfidtat_pkg for the transaction structs and the opcode / result / register codes
package access_table_tb_pkg;
   import rfidtat_pkg::*;

   localparam int TABLE_TAGS = 16;
   localparam int unsigned REPORT_CAP = 40;

   // codes the block must ignore
   localparam logic [2:0]           OP_SPARE     = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   // uid as the table sees it: length capped at ten bytes, unused bytes zero
   function automatic uid_type clamp_uid(input logic [UID_LOW_W-1:0] lo,
                                         input logic [UID_HIGH_W-1:0] hi,
                                         input logic [UID_LEN_W-1:0] len);
      uid_type              u;
      logic [UID_LEN_W-1:0] n;
      logic [UID_LOW_W-1:0] keep;
      n = (len > UID_MAX_LEN) ? UID_MAX_LEN : len;
      u.len = n;
      if (n >= 4'd8) begin
         u.low = lo;
         if (n == UID_MAX_LEN) u.high = hi;
         else if (n == UID_LEN_9) u.high = {8'h00, hi[7:0]};
         else u.high = '0;
      end else begin
         keep   = (64'h1 << (8 * n)) - 64'h1;
         u.low  = lo & keep;
         u.high = '0;
      end
      return u;
   endfunction

   class access_table_scoreboard;
      // table image
      uid_type     slot_uid[TABLE_TAGS];
      bit          slot_active[TABLE_TAGS];
      bit          slot_used[TABLE_TAGS];
      int unsigned used_count;
      // timers and modes
      logic [MS_W-1:0] since_scan;
      logic [MS_W-1:0] buzz_elapsed;
      logic [MS_W-1:0] buzz_len;
      bit              buzzing;
      bit              learning;
      cfg_type         cfg;
      // results still owed by the block, oldest first
      rsp_type     awaited_results[$];
      int unsigned accepted_items;
      int unsigned results_seen;
      int unsigned mismatches;
      int unsigned granted_reads;
      int unsigned kind_seen[8];

      function new();
         foreach (slot_used[i]) begin
            slot_used[i]   = 1'b0;
            slot_active[i] = 1'b0;
            slot_uid[i]    = '0;
         end
         foreach (kind_seen[i]) kind_seen[i] = 0;
         used_count        = 0;
         since_scan        = '0;
         buzz_elapsed      = '0;
         buzz_len          = '0;
         buzzing           = 1'b0;
         learning          = 1'b0;
         cfg.check_enable  = 1'b0;
         cfg.buzzer_enable = 1'b0;
         cfg.debounce_ms   = DEBOUNCE_RESET;
         cfg.beep_ok_ms    = BEEP_OK_RESET;
         cfg.beep_fail_ms  = BEEP_FAIL_RESET;
         cfg.beep_learn_ms = BEEP_LEARN_RESET;
         accepted_items    = 0;
         results_seen      = 0;
         mismatches        = 0;
         granted_reads     = 0;
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [MS_W-1:0] value);
         case (idx)
            REG_CHECK_ENABLE:  cfg.check_enable  = value[0];
            REG_BUZZER_ENABLE: cfg.buzzer_enable = value[0];
            REG_DEBOUNCE_MS:   cfg.debounce_ms   = value;
            REG_BEEP_OK_MS:    cfg.beep_ok_ms    = value;
            REG_BEEP_FAIL_MS:  cfg.beep_fail_ms  = value;
            REG_BEEP_LEARN_MS: cfg.beep_learn_ms = value;
            default: ;
         endcase
      endfunction

      function int lookup(input uid_type u);
         for (int i = 0; i < TABLE_TAGS; i++) begin
            if (slot_used[i] && slot_uid[i] == u) return i;
         end
         return -1;
      endfunction

      function void start_buzz(input logic [MS_W-1:0] len);
         if (cfg.buzzer_enable) begin
            buzzing      = 1'b1;
            buzz_elapsed = '0;
            buzz_len     = len;
         end
      endfunction

      // advance the table by one request and return the result it owes
      function rsp_type step_table(input req_type r);
         uid_type u;
         rsp_type o;
         int      hit;
         bit      granted;
         bit      placed;
         u = clamp_uid(r.uid_low, r.uid_high, r.uid_len);
         o = '0;
         o.result_kind = KIND_NONE;
         case (r.opcode)
            OP_TICK: begin
               if (since_scan != MS_SAT) since_scan++;
               if (buzz_elapsed != MS_SAT) buzz_elapsed++;
               if (buzzing && (buzz_elapsed > buzz_len || buzz_elapsed == MS_SAT)) begin
                  buzzing = 1'b0;
               end
            end
            OP_CARD_READ: begin
               if (!learning && since_scan < cfg.debounce_ms) begin
                  o.result_kind = KIND_DEBOUNCED;
               end else begin
                  since_scan = '0;
                  if (learning) begin
                     learning = 1'b0;
                     start_buzz(cfg.beep_learn_ms);
                     o.result_kind  = KIND_LEARNED;
                     o.out_uid_low  = u.low;
                     o.out_uid_high = u.high;
                     o.out_uid_len  = u.len;
                  end else if (!cfg.check_enable) begin
                     o.result_kind = KIND_CHECK_OFF;
                  end else begin
                     hit     = lookup(u);
                     granted = 1'b0;
                     if (hit >= 0) granted = slot_active[hit];
                     start_buzz(granted ? cfg.beep_ok_ms : cfg.beep_fail_ms);
                     o.result_kind  = KIND_CHECKED;
                     o.authorized   = granted;
                     o.out_uid_low  = u.low;
                     o.out_uid_high = u.high;
                     o.out_uid_len  = u.len;
                  end
               end
            end
            OP_ADD_TAG: begin
               if (lookup(u) >= 0) begin
                  o.result_kind = KIND_APPLIED;
               end else begin
                  // lowest free slot takes the uid
                  placed = 1'b0;
                  for (int i = 0; i < TABLE_TAGS; i++) begin
                     if (!placed && !slot_used[i]) begin
                        slot_used[i]   = 1'b1;
                        slot_active[i] = 1'b1;
                        slot_uid[i]    = u;
                        used_count++;
                        placed = 1'b1;
                     end
                  end
                  o.result_kind = placed ? KIND_APPLIED : KIND_TABLE_FULL;
               end
            end
            OP_TOGGLE_TAG: begin
               hit = lookup(u);
               if (hit >= 0) begin
                  slot_active[hit] = !slot_active[hit];
                  o.result_kind = KIND_APPLIED;
               end else begin
                  o.result_kind = KIND_NO_MATCH;
               end
            end
            OP_DELETE_TAG: begin
               hit = lookup(u);
               if (hit >= 0) begin
                  slot_used[hit] = 1'b0;
                  if (used_count > 0) used_count--;
                  o.result_kind = KIND_APPLIED;
               end else begin
                  o.result_kind = KIND_NO_MATCH;
               end
            end
            OP_CLEAR_ALL: begin
               foreach (slot_used[i]) slot_used[i] = 1'b0;
               used_count = 0;
               o.result_kind = KIND_APPLIED;
            end
            OP_START_LEARN: begin
               learning = 1'b1;
               o.result_kind = KIND_APPLIED;
            end
            default: ;
         endcase
         o.buzzer_level  = buzzing;
         o.learning_flag = learning;
         o.entries_used  = ENTRIES_W'(used_count);
         return o;
      endfunction

      function int unsigned pending_count();
         return awaited_results.size();
      endfunction

      function void note_request(input req_type r);
         accepted_items++;
         awaited_results.insert(awaited_results.size(), step_table(r));
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_field(input string field, input logic [63:0] got, input logic [63:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, field, got, want));
         end
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding: %0h", got));
            return;
         end
         want = awaited_results.pop_front();
         results_seen++;
         kind_seen[want.result_kind]++;
         if (want.authorized) granted_reads++;
         check_field("result_kind", 64'(got.result_kind), 64'(want.result_kind));
         check_field("authorized", 64'(got.authorized), 64'(want.authorized));
         check_field("out_uid_low", got.out_uid_low, want.out_uid_low);
         check_field("out_uid_high", 64'(got.out_uid_high), 64'(want.out_uid_high));
         check_field("out_uid_len", 64'(got.out_uid_len), 64'(want.out_uid_len));
         check_field("buzzer_level", 64'(got.buzzer_level), 64'(want.buzzer_level));
         check_field("learning_flag", 64'(got.learning_flag), 64'(want.learning_flag));
         check_field("entries_used", 64'(got.entries_used), 64'(want.entries_used));
      endtask

      task close_out();
         if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
         end
      endtask
   endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for rfid_tag_access_table_core
// drives requests, register writes and result stalls; depends on rfidtat_pkg and access_table_tb_pkg
module tb_top;
   import rfidtat_pkg::*;
   import access_table_tb_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 4_000_000;
   localparam int          POOL_SIZE    = 28;
   localparam int unsigned TICK_BURST   = 48;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MS_W-1:0]      csr_wdata = '0;

   access_table_scoreboard sb = new();
   uid_type                uid_pool[POOL_SIZE];
   bit                     quiet = 1'b0;
   int unsigned            stall_left = 0;
   int unsigned            cycle_count = 0;
   int unsigned            settings_applied = 0;

   rfid_tag_access_table_core #(
      .TAGS(TABLE_TAGS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic uid_type random_uid();
      return clamp_uid({$urandom, $urandom}, 16'($urandom), 4'($urandom_range(0, 15)));
   endfunction

   // present a uid with junk in the bytes past its length
   function automatic req_type dress_uid(input logic [2:0] op, input uid_type u);
      req_type              r;
      logic [UID_LOW_W-1:0] keep;
      r.opcode   = op;
      r.uid_len  = u.len;
      r.uid_low  = u.low;
      r.uid_high = 16'($urandom);
      if (u.len < 4'd8) begin
         keep      = (64'h1 << (8 * u.len)) - 64'h1;
         r.uid_low = u.low | ({$urandom, $urandom} & ~keep);
      end
      if (u.len == UID_LEN_9) r.uid_high = {8'($urandom), u.high[7:0]};
      if (u.len == UID_MAX_LEN) begin
         r.uid_high = u.high;
         r.uid_len  = 4'($urandom_range(10, 15));
      end
      return r;
   endfunction

   function automatic req_type exact_item(input logic [2:0] op,
                                          input logic [UID_LOW_W-1:0] lo,
                                          input logic [UID_HIGH_W-1:0] hi,
                                          input logic [UID_LEN_W-1:0] len);
      req_type r;
      r.opcode   = op;
      r.uid_low  = lo;
      r.uid_high = hi;
      r.uid_len  = len;
      return r;
   endfunction

   // one request transaction; valid stays up for a back-to-back follower
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = quiet ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off the sender until every owed result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // full register set, junk in the unused bits of the one-bit enables
   task automatic apply_settings(input bit check, input bit buzz,
                                 input logic [MS_W-1:0] debounce,
                                 input logic [MS_W-1:0] ok_ms,
                                 input logic [MS_W-1:0] fail_ms,
                                 input logic [MS_W-1:0] learn_ms,
                                 input bit with_spare);
      write_csr(REG_CHECK_ENABLE, {15'($urandom), check});
      write_csr(REG_BUZZER_ENABLE, {15'($urandom), buzz});
      write_csr(REG_DEBOUNCE_MS, debounce);
      write_csr(REG_BEEP_OK_MS, ok_ms);
      write_csr(REG_BEEP_FAIL_MS, fail_ms);
      write_csr(REG_BEEP_LEARN_MS, learn_ms);
      if (with_spare) begin
         write_csr(REG_SPARE_LO, 16'($urandom));
         write_csr(REG_SPARE_HI, 16'($urandom));
      end
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // random traffic over a shared uid pool so reads hit the table
   task automatic run_phase(input int unsigned count);
      int unsigned done;
      int unsigned pick;
      uid_type     u;
      logic [2:0]  op;
      done = 0;
      while (done < count) begin
         if (done % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 34) op = OP_TICK;
         else if (pick < 60) op = OP_CARD_READ;
         else if (pick < 72) op = OP_ADD_TAG;
         else if (pick < 80) op = OP_TOGGLE_TAG;
         else if (pick < 86) op = OP_DELETE_TAG;
         else if (pick < 87) op = OP_CLEAR_ALL;
         else if (pick < 93) op = OP_START_LEARN;
         else if (pick < 98) op = OP_CARD_READ;
         else op = OP_SPARE;
         u = ($urandom_range(0, 9) == 0) ? random_uid()
                                         : uid_pool[$urandom_range(0, POOL_SIZE - 1)];
         send_item(dress_uid(op, u));
         if (op != OP_SPARE) done++;
         if ($urandom_range(0, 149) == 0) wait_drained();
      end
      wait_drained();
      quiet = 1'b0;
   endtask

   // result side stalls
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 99) < 25) stall_left <= idle_len();
      end
   end

   // every accepted transaction on the three channels goes to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("rfid_tag_access_table_core verification failed");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (uid_pool[i]) uid_pool[i] = random_uid();

      // reset defaults: read inside the debounce window, learn bypasses it
      send_item(exact_item(OP_CARD_READ, '1, '1, 4'd7));
      send_item(exact_item(OP_START_LEARN, '0, '0, '0));
      send_item(exact_item(OP_CARD_READ, 64'h0123_4567_89ab_cdef, 16'hbeef, 4'd15));
      send_item(exact_item(OP_SPARE, '1, '1, 4'd15));
      send_item(exact_item(OP_TICK, '1, '1, 4'd15));
      wait_drained();

      // directed table commands: empty and full-length uids, length above ten
      apply_settings(1'b1, 1'b1, 16'd0, 16'd2, 16'd3, 16'd1, 1'b1);
      send_item(exact_item(OP_ADD_TAG, '1, '1, '0));
      send_item(exact_item(OP_ADD_TAG, '1, '1, UID_MAX_LEN));
      send_item(exact_item(OP_ADD_TAG, '1, '1, 4'd12));
      send_item(exact_item(OP_CARD_READ, '1, '1, UID_MAX_LEN));
      send_item(exact_item(OP_TOGGLE_TAG, '1, '1, UID_MAX_LEN));
      send_item(exact_item(OP_CARD_READ, '1, '1, 4'd15));
      send_item(exact_item(OP_TOGGLE_TAG, 64'h0123_4567_89ab_cdef, '0, 4'd8));
      send_item(exact_item(OP_DELETE_TAG, '1, 16'h00ff, UID_LEN_9));
      send_item(exact_item(OP_DELETE_TAG, '0, '0, '0));
      repeat (4) send_item(exact_item(OP_TICK, '0, '0, '0));
      send_item(exact_item(OP_START_LEARN, '0, '0, '0));
      send_item(exact_item(OP_TICK, '0, '0, '0));
      send_item(exact_item(OP_CARD_READ, 64'h0000_0000_dead_beef, '0, 4'd4));
      send_item(exact_item(OP_CLEAR_ALL, '0, '0, '0));
      send_item(exact_item(OP_SPARE, '0, '0, '0));
      wait_drained();

      // longest beep and debounce, then a back-to-back burst of ticks
      apply_settings(1'b1, 1'b1, MS_SAT, 16'd0, 16'd0, MS_SAT, 1'b0);
      quiet = 1'b1;
      send_item(exact_item(OP_START_LEARN, '0, '0, '0));
      send_item(exact_item(OP_CARD_READ, '1, '1, UID_MAX_LEN));
      for (int unsigned k = 0; k < TICK_BURST; k++) send_item(exact_item(OP_TICK, '0, '0, '0));
      send_item(exact_item(OP_CARD_READ, '1, '1, UID_MAX_LEN));
      send_item(exact_item(OP_TICK, '0, '0, '0));
      wait_drained();
      quiet = 1'b0;

      // random phases across register settings
      apply_settings(1'b1, 1'b1, 16'd2, 16'd3, 16'd6, 16'd2, 1'b0);
      run_phase(320);
      apply_settings(1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
      run_phase(320);
      apply_settings(1'b1, 1'b0, 16'd1, 16'd5, 16'd5, 16'd5, 1'b0);
      run_phase(320);
      apply_settings(1'b1, 1'b1, MS_SAT, MS_SAT, MS_SAT, MS_SAT, 1'b0);
      run_phase(320);
      apply_settings(1'b1, 1'b1, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)), 1'b1);
      run_phase(320);

      // let any late result show up
      wait_drained();
      repeat (4 * TABLE_TAGS) @(posedge clock);
      sb.close_out();

      $display("covered %0d transactions under %0d register settings:",
               sb.accepted_items, settings_applied);
      $display("  %0d checked (%0d granted), %0d learned, %0d debounced, %0d with checking off",
               sb.kind_seen[KIND_CHECKED], sb.granted_reads, sb.kind_seen[KIND_LEARNED],
               sb.kind_seen[KIND_DEBOUNCED], sb.kind_seen[KIND_CHECK_OFF]);
      $display("  %0d table full, %0d no match; %0d mismatches",
               sb.kind_seen[KIND_TABLE_FULL], sb.kind_seen[KIND_NO_MATCH], sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("rfid_tag_access_table_core verification clean");
      end else begin
         $display("rfid_tag_access_table_core verification failed");
      end
      $finish;
   end

endmodule
